>>> sv/sit_pkg.sv
// Shared types and constants for the sorted interval table.
package sit_pkg;

   localparam int DEF_ENTRIES = 64;
   localparam int POS_W       = 32;
   localparam int SLOT_W      = 7;
   localparam int COUNT_W     = 7;
   localparam int CSR_IDX_W   = 8;

   // Operation codes.
   localparam logic [1:0] OP_ADD   = 2'd0;
   localparam logic [1:0] OP_DEL   = 2'd1;
   localparam logic [1:0] OP_GET   = 2'd2;
   localparam logic [1:0] OP_PURGE = 2'd3;

   // Register indexes.
   localparam logic [CSR_IDX_W-1:0] REG_WINDOW_LOW  = 8'd0;
   localparam logic [CSR_IDX_W-1:0] REG_WINDOW_HIGH = 8'd1;

   typedef struct packed {
      logic [1:0]        opcode;
      logic [POS_W-1:0]  start_pos;
      logic [POS_W-1:0]  end_pos;
      logic [SLOT_W-1:0] slot;
   } req_type;

   typedef struct packed {
      logic               status;
      logic [SLOT_W-1:0]  placed_at;
      logic [POS_W-1:0]   found_start;
      logic [POS_W-1:0]   found_end;
      logic [COUNT_W-1:0] entry_count;
   } rsp_type;

   typedef enum logic [3:0] {
      S_IDLE, S_DISPATCH, S_ADD_RD, S_ADD_CMP, S_ADD_CHK, S_SH_RD, S_SH_WR,
      S_DEL_RD, S_DEL_WR, S_GET, S_PU_RD, S_PU_CHK
   } state_type;

   typedef enum logic [1:0] {ADDR_K, ADDR_I, ADDR_IM1, ADDR_IP1} addr_sel_type;
   typedef enum logic [2:0] {I_HOLD, I_ZERO, I_COUNT, I_SLOT, I_INC, I_DEC} i_op_type;
   typedef enum logic [1:0] {K_HOLD, K_ZERO, K_INC} k_op_type;
   typedef enum logic [1:0] {C_HOLD, C_INC, C_DEC, C_LOAD_K} count_op_type;

   // Commands from controller to datapath.
   typedef struct packed {
      logic         load;
      logic         rd;
      addr_sel_type rd_sel;
      logic         wr;
      addr_sel_type wr_sel;
      logic         wr_new;
      i_op_type     i_op;
      k_op_type     k_op;
      count_op_type count_op;
      logic         prev_load;
      logic         done;
      logic         fail;
      logic         placed;
      logic         found;
   } cmd_type;

   // Status from datapath to controller.
   typedef struct packed {
      logic [1:0] opcode;
      logic       add_ok;
      logic       slot_ok;
      logic       start_le_end;
      logic       prev_ok;
      logic       i_eq_k;
      logic       i_eq_count;
      logic       ip1_lt_count;
      logic       k_eq_count;
      logic       rd_in_win;
   } stat_type;

endpackage

>>> sv/sit_ram.sv
// Generic single write port RAM with registered read.
module sit_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // Write and registered read.
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;
endmodule

>>> sv/sit_ctrl.sv
// Controller state machine that sequences scans and shifts of the table.
module sit_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  sit_pkg::stat_type stat,
   output sit_pkg::cmd_type  cmd
);
   sit_pkg::state_type state_ff, state_in;

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sit_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != sit_pkg::S_IDLE);

   // Next state and commands.
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         sit_pkg::S_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = sit_pkg::S_DISPATCH;
            end
         end
         sit_pkg::S_DISPATCH: begin
            unique case (stat.opcode)
               sit_pkg::OP_ADD: begin
                  if (stat.add_ok) begin
                     cmd.k_op = sit_pkg::K_ZERO;
                     state_in = sit_pkg::S_ADD_RD;
                  end else begin
                     cmd.done = 1'b1;
                     cmd.fail = 1'b1;
                     state_in = sit_pkg::S_IDLE;
                  end
               end
               sit_pkg::OP_DEL: begin
                  if (stat.slot_ok) begin
                     cmd.i_op = sit_pkg::I_SLOT;
                     state_in = sit_pkg::S_DEL_RD;
                  end else begin
                     cmd.done = 1'b1;
                     cmd.fail = 1'b1;
                     state_in = sit_pkg::S_IDLE;
                  end
               end
               sit_pkg::OP_GET: begin
                  if (stat.slot_ok) begin
                     cmd.i_op = sit_pkg::I_SLOT;
                     state_in = sit_pkg::S_GET;
                  end else begin
                     cmd.done = 1'b1;
                     cmd.fail = 1'b1;
                     state_in = sit_pkg::S_IDLE;
                  end
               end
               default: begin
                  cmd.i_op = sit_pkg::I_ZERO;
                  cmd.k_op = sit_pkg::K_ZERO;
                  state_in = sit_pkg::S_PU_RD;
               end
            endcase
         end
         // Find the first entry whose start lies above the new end.
         sit_pkg::S_ADD_RD: begin
            if (stat.k_eq_count) begin
               state_in = sit_pkg::S_ADD_CHK;
            end else begin
               cmd.rd     = 1'b1;
               cmd.rd_sel = sit_pkg::ADDR_K;
               state_in   = sit_pkg::S_ADD_CMP;
            end
         end
         sit_pkg::S_ADD_CMP: begin
            if (stat.start_le_end) begin
               cmd.prev_load = 1'b1;
               cmd.k_op      = sit_pkg::K_INC;
               state_in      = sit_pkg::S_ADD_RD;
            end else begin
               state_in = sit_pkg::S_ADD_CHK;
            end
         end
         sit_pkg::S_ADD_CHK: begin
            if (stat.prev_ok) begin
               cmd.i_op = sit_pkg::I_COUNT;
               state_in = sit_pkg::S_SH_RD;
            end else begin
               cmd.done = 1'b1;
               cmd.fail = 1'b1;
               state_in = sit_pkg::S_IDLE;
            end
         end
         // Shift entries up by one from the top down to the insertion point.
         sit_pkg::S_SH_RD: begin
            if (stat.i_eq_k) begin
               cmd.wr       = 1'b1;
               cmd.wr_sel   = sit_pkg::ADDR_K;
               cmd.wr_new   = 1'b1;
               cmd.count_op = sit_pkg::C_INC;
               cmd.done     = 1'b1;
               cmd.placed   = 1'b1;
               state_in     = sit_pkg::S_IDLE;
            end else begin
               cmd.rd     = 1'b1;
               cmd.rd_sel = sit_pkg::ADDR_IM1;
               state_in   = sit_pkg::S_SH_WR;
            end
         end
         sit_pkg::S_SH_WR: begin
            cmd.wr     = 1'b1;
            cmd.wr_sel = sit_pkg::ADDR_I;
            cmd.i_op   = sit_pkg::I_DEC;
            state_in   = sit_pkg::S_SH_RD;
         end
         // Close the gap left by a deleted entry.
         sit_pkg::S_DEL_RD: begin
            if (stat.ip1_lt_count) begin
               cmd.rd     = 1'b1;
               cmd.rd_sel = sit_pkg::ADDR_IP1;
               state_in   = sit_pkg::S_DEL_WR;
            end else begin
               cmd.count_op = sit_pkg::C_DEC;
               cmd.done     = 1'b1;
               state_in     = sit_pkg::S_IDLE;
            end
         end
         sit_pkg::S_DEL_WR: begin
            cmd.wr     = 1'b1;
            cmd.wr_sel = sit_pkg::ADDR_I;
            cmd.i_op   = sit_pkg::I_INC;
            state_in   = sit_pkg::S_DEL_RD;
         end
         // It first reads the slot and parks i at the count, then returns the
         // registered read data once i equals the count.
         sit_pkg::S_GET: begin
            if (stat.i_eq_count) begin
               cmd.done  = 1'b1;
               cmd.found = 1'b1;
               state_in  = sit_pkg::S_IDLE;
            end else begin
               cmd.rd     = 1'b1;
               cmd.rd_sel = sit_pkg::ADDR_I;
               cmd.i_op   = sit_pkg::I_COUNT;
            end
         end
         // Compact the entries that remain inside the window.
         sit_pkg::S_PU_RD: begin
            if (stat.i_eq_count) begin
               cmd.count_op = sit_pkg::C_LOAD_K;
               cmd.done     = 1'b1;
               state_in     = sit_pkg::S_IDLE;
            end else begin
               cmd.rd     = 1'b1;
               cmd.rd_sel = sit_pkg::ADDR_I;
               state_in   = sit_pkg::S_PU_CHK;
            end
         end
         sit_pkg::S_PU_CHK: begin
            if (stat.rd_in_win) begin
               cmd.wr     = 1'b1;
               cmd.wr_sel = sit_pkg::ADDR_K;
               cmd.k_op   = sit_pkg::K_INC;
            end
            cmd.i_op = sit_pkg::I_INC;
            state_in = sit_pkg::S_PU_RD;
         end
         default: begin
            state_in = sit_pkg::S_IDLE;
         end
      endcase
   end

   // A result beat always returns the controller to idle.
   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.done |-> state_in == sit_pkg::S_IDLE)
      else $error("result beat without return to idle");

   // An accepted command always leaves idle.
   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted command did not start");

   // Writes never happen while idle.
   a_idle_quiet: assert property (@(posedge clock) disable iff (reset)
      !busy |-> !cmd.wr)
      else $error("table write while idle");
endmodule

>>> sv/sit_dpath.sv
// Datapath: window registers, table RAM, counters and the result register.
module sit_dpath #(
   parameter int ENTRIES = sit_pkg::DEF_ENTRIES
) (
   input  logic                            clock,
   input  logic                            reset,
   input  sit_pkg::req_type                req_item,
   input  logic                            csr_valid,
   input  logic [sit_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [sit_pkg::POS_W-1:0]       csr_data,
   input  sit_pkg::cmd_type                cmd,
   output sit_pkg::stat_type               stat,
   output logic                            rsp_strobe,
   output sit_pkg::rsp_type                rsp_item
);
   localparam int AW = $clog2(ENTRIES);
   localparam int CW = $clog2(ENTRIES + 1);
   localparam int PW = sit_pkg::POS_W;

   sit_pkg::req_type req_ff;
   logic [PW-1:0]    win_low_ff, win_high_ff;
   logic [CW-1:0]    i_ff, i_in, k_ff, k_in, count_ff, count_in;
   logic [PW-1:0]    prev_end_ff;
   logic             rsp_strobe_ff;
   sit_pkg::rsp_type rsp_ff, rsp_in;
   logic [CW-1:0]    rd_idx, wr_idx;
   logic [2*PW-1:0]  rdata, wdata;
   logic [PW-1:0]    rd_start, rd_end;

   function automatic logic in_window(input logic [PW-1:0] s, input logic [PW-1:0] e,
                                      input logic [PW-1:0] lo, input logic [PW-1:0] hi);
      in_window = (s >= lo) && (s < hi) && (e > lo) && (e <= hi);
   endfunction

   assign rd_start = rdata[2*PW-1:PW];
   assign rd_end   = rdata[PW-1:0];

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         win_low_ff  <= '0;
         win_high_ff <= PW'(1);
      end else if (csr_valid) begin
         if (csr_index == sit_pkg::REG_WINDOW_LOW) begin
            win_low_ff <= csr_data;
         end
         if (csr_index == sit_pkg::REG_WINDOW_HIGH) begin
            win_high_ff <= csr_data;
         end
      end
   end

   // Counter next values.
   always_comb begin
      case (cmd.i_op)
         sit_pkg::I_ZERO:  i_in = '0;
         sit_pkg::I_COUNT: i_in = count_ff;
         sit_pkg::I_SLOT:  i_in = CW'(req_ff.slot);
         sit_pkg::I_INC:   i_in = i_ff + CW'(1);
         sit_pkg::I_DEC:   i_in = i_ff - CW'(1);
         default:          i_in = i_ff;
      endcase
      case (cmd.k_op)
         sit_pkg::K_ZERO: k_in = '0;
         sit_pkg::K_INC:  k_in = k_ff + CW'(1);
         default:         k_in = k_ff;
      endcase
      case (cmd.count_op)
         sit_pkg::C_INC:    count_in = count_ff + CW'(1);
         sit_pkg::C_DEC:    count_in = count_ff - CW'(1);
         sit_pkg::C_LOAD_K: count_in = k_ff;
         default:           count_in = count_ff;
      endcase
   end

   // Address selection.
   always_comb begin
      case (cmd.rd_sel)
         sit_pkg::ADDR_K:   rd_idx = k_ff;
         sit_pkg::ADDR_IM1: rd_idx = i_ff - CW'(1);
         sit_pkg::ADDR_IP1: rd_idx = i_ff + CW'(1);
         default:           rd_idx = i_ff;
      endcase
      case (cmd.wr_sel)
         sit_pkg::ADDR_K: wr_idx = k_ff;
         default:         wr_idx = i_ff;
      endcase
      wdata = cmd.wr_new ? {req_ff.start_pos, req_ff.end_pos} : rdata;
   end

   // Control and working registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         count_ff      <= count_in;
         rsp_strobe_ff <= cmd.done;
      end
      i_ff <= i_in;
      k_ff <= k_in;
      if (cmd.load) begin
         req_ff <= req_item;
      end
      if (cmd.prev_load) begin
         prev_end_ff <= rd_end;
      end
      if (cmd.done) begin
         rsp_ff <= rsp_in;
      end
   end

   // Result beat.
   always_comb begin
      rsp_in.status      = cmd.fail;
      rsp_in.placed_at   = cmd.placed ? sit_pkg::SLOT_W'(k_ff) : '0;
      rsp_in.found_start = cmd.found ? rd_start : '0;
      rsp_in.found_end   = cmd.found ? rd_end : '0;
      rsp_in.entry_count = sit_pkg::COUNT_W'(count_in);
   end

   sit_ram #(.WIDTH(2 * PW), .DEPTH(ENTRIES)) u_table (
      .clock (clock),
      .we    (cmd.wr),
      .waddr (wr_idx[AW-1:0]),
      .wdata (wdata),
      .raddr (rd_idx[AW-1:0]),
      .rdata (rdata)
   );

   // Status toward the controller.
   always_comb begin
      stat.opcode       = req_ff.opcode;
      stat.add_ok       = (req_ff.start_pos < req_ff.end_pos)
                          && in_window(req_ff.start_pos, req_ff.end_pos,
                                       win_low_ff, win_high_ff)
                          && ({1'b0, count_ff} < (CW + 1)'(ENTRIES));
      stat.slot_ok      = (8'(req_ff.slot) < 8'(count_ff));
      stat.start_le_end = (rd_start <= req_ff.end_pos);
      stat.prev_ok      = (k_ff == '0) || (prev_end_ff < req_ff.start_pos);
      stat.i_eq_k       = (i_ff == k_ff);
      stat.i_eq_count   = (i_ff == count_ff);
      stat.ip1_lt_count = (({1'b0, i_ff} + (CW + 1)'(1)) < {1'b0, count_ff});
      stat.k_eq_count   = (k_ff == count_ff);
      stat.rd_in_win    = in_window(rd_start, rd_end, win_low_ff, win_high_ff);
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_item   = rsp_ff;

   // Fill level stays within the table.
   a_count_max: assert property (@(posedge clock) disable iff (reset)
      {1'b0, count_ff} <= (CW + 1)'(ENTRIES))
      else $error("entry count above table size");

   // Writes stay inside the table.
   a_wr_range: assert property (@(posedge clock) disable iff (reset)
      cmd.wr |-> ({1'b0, wr_idx} < (CW + 1)'(ENTRIES)))
      else $error("table write out of range");

   // Results are single-cycle beats and never come back to back.
   a_rsp_pulse: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe_ff |=> !rsp_strobe_ff)
      else $error("back to back result beats");
endmodule

>>> sv/sorted_interval_table.sv
// Top level of the sorted interval table: controller, datapath and ports.
//
//   channel  | handshake            | payload
//   req_     | start, busy          | req_item (opcode, start_pos, end_pos, slot)
//   rsp_     | rsp_strobe           | rsp_item (status, placed_at, found_*, entry_count)
//   csr_     | csr_valid, csr_ready | csr_index, csr_data
//
// A get reads its slot and then returns the data; a command rejected at dispatch ends
// there. An add scans the table entry by entry, then shifts each moved entry with a read
// and a write; a delete or purge walks entry by entry, as the single read port requires.
// Reset is synchronous and clears the control state and the window registers.
// The receiver cannot stall; each result beat is one cycle on rsp_strobe.
module sorted_interval_table #(
   parameter int ENTRIES = sit_pkg::DEF_ENTRIES
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  sit_pkg::req_type              req_item,
   output logic                          rsp_strobe,
   output sit_pkg::rsp_type              rsp_item,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [sit_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [sit_pkg::POS_W-1:0]     csr_data
);
   sit_pkg::cmd_type  cmd;
   sit_pkg::stat_type stat;

   assign csr_ready = 1'b1;

   sit_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .stat  (stat),
      .cmd   (cmd)
   );

   sit_dpath #(.ENTRIES(ENTRIES)) u_dpath (
      .clock      (clock),
      .reset      (reset),
      .req_item   (req_item),
      .csr_valid  (csr_valid),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .cmd        (cmd),
      .stat       (stat),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item)
   );
endmodule

>>> verif/sit_checker.sv
// Checker for the sorted interval table: watches the channels, predicts results, compares.
`timescale 1ns / 1ps
module sit_checker #(
   parameter int ENTRIES = sit_pkg::DEF_ENTRIES
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic                          busy,
   input  sit_pkg::req_type              req_item,
   input  logic                          rsp_strobe,
   input  sit_pkg::rsp_type              rsp_item,
   input  logic                          csr_valid,
   input  logic                          csr_ready,
   input  logic [sit_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [sit_pkg::POS_W-1:0]     csr_data,
   output int                            fail_count,
   output int                            pending
);
   localparam int PW  = sit_pkg::POS_W;
   localparam int SW  = sit_pkg::SLOT_W;
   localparam int CNW = sit_pkg::COUNT_W;

   logic [PW-1:0]    win_lo, win_hi;
   logic [PW-1:0]    lo_tab [ENTRIES];
   logic [PW-1:0]    hi_tab [ENTRIES];
   int               fill;
   sit_pkg::rsp_type rsp_queue [$];

   function automatic bit within_window(logic [PW-1:0] s, logic [PW-1:0] e);
      return s >= win_lo && s < win_hi && e > win_lo && e <= win_hi;
   endfunction

   // Applies one command to the shadow table and returns its result.
   function automatic sit_pkg::rsp_type apply_command(sit_pkg::req_type r);
      sit_pkg::rsp_type o;
      int               k;
      o = '0;
      o.status = 1'b1;
      case (r.opcode)
         sit_pkg::OP_ADD: begin
            if (r.start_pos < r.end_pos && within_window(r.start_pos, r.end_pos)
                && fill < ENTRIES) begin
               k = 0;
               while (k < fill && lo_tab[k] <= r.end_pos) k++;
               if (k == 0 || hi_tab[k-1] < r.start_pos) begin
                  for (int i = fill; i > k; i--) begin
                     lo_tab[i] = lo_tab[i-1];
                     hi_tab[i] = hi_tab[i-1];
                  end
                  lo_tab[k] = r.start_pos;
                  hi_tab[k] = r.end_pos;
                  fill++;
                  o.status = 1'b0;
                  o.placed_at = SW'(k);
               end
            end
         end
         sit_pkg::OP_DEL: begin
            if (r.slot < fill) begin
               for (int i = r.slot; i + 1 < fill; i++) begin
                  lo_tab[i] = lo_tab[i+1];
                  hi_tab[i] = hi_tab[i+1];
               end
               fill--;
               o.status = 1'b0;
            end
         end
         sit_pkg::OP_GET: begin
            if (r.slot < fill) begin
               o.found_start = lo_tab[r.slot];
               o.found_end   = hi_tab[r.slot];
               o.status      = 1'b0;
            end
         end
         default: begin
            k = 0;
            for (int i = 0; i < fill; i++) begin
               if (within_window(lo_tab[i], hi_tab[i])) begin
                  lo_tab[k] = lo_tab[i];
                  hi_tab[k] = hi_tab[i];
                  k++;
               end
            end
            fill = k;
            o.status = 1'b0;
         end
      endcase
      o.entry_count = CNW'(fill);
      return o;
   endfunction

   assign pending = rsp_queue.size();

   // Track register writes, accepted commands and result beats.
   always @(posedge clock) begin
      sit_pkg::rsp_type want;
      if (reset) begin
         win_lo = '0;
         win_hi = 1;
         fill = 0;
         fail_count = 0;
         rsp_queue.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            if (csr_index == sit_pkg::REG_WINDOW_LOW) win_lo = csr_data;
            else if (csr_index == sit_pkg::REG_WINDOW_HIGH) win_hi = csr_data;
         end
         if (rsp_strobe) begin
            if (rsp_queue.size() == 0) begin
               fail_count++;
               if (fail_count <= 10) $display("unexpected result beat %p", rsp_item);
            end else begin
               want = rsp_queue.pop_front();
               if (rsp_item !== want) begin
                  fail_count++;
                  if (fail_count <= 10)
                     $display("mismatch: expected %p, got %p", want, rsp_item);
               end
            end
         end
         if (start && !busy) rsp_queue.insert(rsp_queue.size(), apply_command(req_item));
      end
   end
endmodule

>>> verif/tb_top.sv
// Testbench top for the sorted interval table: stimulus, reset and verdict.
`timescale 1ns / 1ps
module tb_top;
   localparam int PW  = sit_pkg::POS_W;
   localparam int SLW = sit_pkg::SLOT_W;
   localparam int IW  = sit_pkg::CSR_IDX_W;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             start = 1'b0;
   logic             busy;
   sit_pkg::req_type req_item = '0;
   logic             rsp_strobe;
   sit_pkg::rsp_type rsp_item;
   logic             csr_valid = 1'b0;
   logic             csr_ready;
   logic [IW-1:0]    csr_index = '0;
   logic [PW-1:0]    csr_data = '0;
   int               fail_count, pending;
   int               cycles = 0;
   logic [PW-1:0]    lo, hi;

   sorted_interval_table i_dut (.*);
   sit_checker u_checker (.*);

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Watchdog against a hung handshake.
   always @(posedge clock) begin
      cycles++;
      if (cycles > 2000000) begin
         $display("tb_top: errors");
         $finish;
      end
   end

   // Writes one register and returns after dropping valid.
   task automatic write_reg(logic [IW-1:0] idx, logic [PW-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
      @(negedge clock);
   endtask

   // Waits until all results are in and the block has gone idle.
   task automatic drain();
      while (pending != 0 || busy) @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   task automatic set_window(logic [PW-1:0] l, logic [PW-1:0] h);
      drain();
      write_reg(sit_pkg::REG_WINDOW_LOW, l);
      write_reg(sit_pkg::REG_WINDOW_HIGH, h);
      lo = l;
      hi = h;
   endtask

   // Sends one command beat; start stays high only across the accepting edge.
   // The block stays busy the cycle after acceptance, so the extra falling
   // edge at the end costs no throughput.
   task automatic issue(logic [1:0] op, logic [PW-1:0] s, logic [PW-1:0] e,
                        logic [SLW-1:0] sl);
      req_item <= '{opcode: op, start_pos: s, end_pos: e, slot: sl};
      start    <= 1'b1;
      do @(posedge clock); while (busy);
      @(negedge clock);
      start <= 1'b0;
      @(negedge clock);
   endtask

   // Adds that start inside the window, plus random adds, deletes, gets and purges.
   task automatic random_item();
      logic [PW-1:0] s, e, span;
      int            pick;
      pick = $urandom_range(0, 99);
      span = hi - lo;
      if (pick < 45 && hi > lo) begin
         s = lo + ($urandom % span);
         e = s + $urandom_range(1, 40);
         issue(sit_pkg::OP_ADD, s, e, '0);
      end else if (pick < 55) begin
         issue(sit_pkg::OP_ADD, $urandom, $urandom, SLW'($urandom));
      end else if (pick < 70) begin
         issue(sit_pkg::OP_DEL, $urandom, $urandom, SLW'($urandom_range(0, 70)));
      end else if (pick < 94) begin
         issue(sit_pkg::OP_GET, $urandom, $urandom, SLW'($urandom_range(0, 70)));
      end else if (pick < 97) begin
         issue(sit_pkg::OP_GET, $urandom, $urandom, SLW'($urandom));
      end else begin
         issue(sit_pkg::OP_PURGE, $urandom, $urandom, SLW'($urandom));
      end
   endtask

   initial begin
      lo = '0;
      hi = 1;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed: reset window, extremes, touching, bad index and purge.
      issue(sit_pkg::OP_ADD, 0, 1, 0);
      issue(sit_pkg::OP_ADD, 0, 1, 0);
      issue(sit_pkg::OP_GET, 0, 0, 0);
      issue(sit_pkg::OP_GET, 0, 0, 1);
      issue(sit_pkg::OP_GET, 0, 0, 7'h7f);
      set_window(32'd100, 32'hffff_ffff);
      issue(sit_pkg::OP_ADD, 32'd200, 32'd300, 0);
      issue(sit_pkg::OP_ADD, 32'd300, 32'd400, 0);
      issue(sit_pkg::OP_ADD, 32'd150, 32'd200, 0);
      issue(sit_pkg::OP_ADD, 32'd100, 32'd149, 0);
      issue(sit_pkg::OP_ADD, 32'd301, 32'd400, 0);
      issue(sit_pkg::OP_ADD, 32'd500, 32'd500, 0);
      issue(sit_pkg::OP_ADD, 32'd99, 32'd120, 0);
      issue(sit_pkg::OP_ADD, 32'hffff_fff0, 32'hffff_ffff, 0);
      issue(sit_pkg::OP_ADD, 32'hffff_ffff, 32'hffff_ffff, 0);
      issue(sit_pkg::OP_GET, 0, 0, 2);
      issue(sit_pkg::OP_GET, 0, 0, 3);
      issue(sit_pkg::OP_DEL, 0, 0, 1);
      issue(sit_pkg::OP_DEL, 0, 0, 7'h7f);
      set_window(32'd250, 32'd200);
      issue(sit_pkg::OP_ADD, 32'd210, 32'd220, 0);
      issue(sit_pkg::OP_PURGE, 0, 0, 0);
      set_window(32'hffff_ffff, 32'hffff_ffff);
      issue(sit_pkg::OP_PURGE, 32'hffff_ffff, 32'hffff_ffff, 7'h7f);

      // Random phases across several windows, with bursts and gaps.
      for (int ph = 0; ph < 6; ph++) begin
         case (ph)
            0: set_window(32'd0, 32'd3000);
            1: set_window($urandom_range(0, 1000), 32'hffff_ffff);
            2: set_window(32'd0, 32'd800);
            3: set_window(32'hffff_f000, 32'hffff_ffff);
            4: set_window(32'd500, 32'd2500);
            default: set_window(32'd0, 32'd5000);
         endcase
         for (int n = 0; n < 220; n++) begin
            random_item();
            if ($urandom_range(0, 7) == 0) repeat ($urandom_range(1, 20)) @(negedge clock);
            if ($urandom_range(0, 150) == 0) drain();
         end
      end

      drain();
      repeat (300) @(negedge clock);
      if (fail_count == 0 && pending == 0) begin
         $display("tb_top: clean");
      end else begin
         $display("tb_top: errors");
      end
      $finish;
   end
endmodule
